>>> hw/rtl/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIM       = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MUL  = 1'b1;

    typedef logic signed [DATA_W-1:0]     t_data;
    typedef logic signed [2*DATA_W-1:0]   t_prod;
    typedef logic signed [2*DATA_W:0]     t_pair;
    typedef logic signed [2*DATA_W+1:0]   t_sum;
    typedef logic [1:0]                   t_col;

    localparam t_data SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic en1;
        logic en2;
    } t_stage_ctl;

endpackage

>>> hw/rtl/mm4_if.sv
`timescale 1ns / 1ps

interface mm4_in_if;
    logic            valid;
    logic            ready;
    logic            operation;
    mm4_pkg::t_col   column;
    mm4_pkg::t_data  elem_0;
    mm4_pkg::t_data  elem_1;
    mm4_pkg::t_data  elem_2;
    mm4_pkg::t_data  elem_3;

    modport source (output valid, operation, column, elem_0, elem_1, elem_2, elem_3,
                    input ready);
    modport sink   (input valid, operation, column, elem_0, elem_1, elem_2, elem_3,
                    output ready);
endinterface

interface mm4_out_if;
    logic            valid;
    logic            ready;
    mm4_pkg::t_col   result_column;
    mm4_pkg::t_data  out_0;
    mm4_pkg::t_data  out_1;
    mm4_pkg::t_data  out_2;
    mm4_pkg::t_data  out_3;
    logic            saturated;

    modport source (output valid, result_column, out_0, out_1, out_2, out_3, saturated,
                    input ready);
    modport sink   (input valid, result_column, out_0, out_1, out_2, out_3, saturated,
                    output ready);
endinterface

>>> hw/rtl/mm4_lane.sv
`timescale 1ns / 1ps

// one product row: four multipliers, pair adds, final add and clamp
module mm4_lane (
    input  logic                i_clk,
    input  mm4_pkg::t_stage_ctl i_ctl,
    input  mm4_pkg::t_data      i_a [mm4_pkg::DIM],
    input  mm4_pkg::t_data      i_b [mm4_pkg::DIM],
    output mm4_pkg::t_data      o_value,
    output logic                o_sat
);

    mm4_pkg::t_prod r_prod [mm4_pkg::DIM];
    mm4_pkg::t_prod n_prod [mm4_pkg::DIM];
    mm4_pkg::t_pair r_pair [2];
    mm4_pkg::t_pair n_pair [2];
    mm4_pkg::t_sum  w_sum;

    always_comb begin
        for (int k = 0; k < mm4_pkg::DIM; k++) begin
            n_prod[k] = mm4_pkg::t_prod'(i_a[k]) * mm4_pkg::t_prod'(i_b[k]);
        end
        for (int p = 0; p < 2; p++) begin
            n_pair[p] = mm4_pkg::t_pair'(r_prod[2*p]   >>> mm4_pkg::FRAC_BITS)
                      + mm4_pkg::t_pair'(r_prod[2*p+1] >>> mm4_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_prod <= n_prod;
        end
        if (i_ctl.en2) begin
            r_pair <= n_pair;
        end
    end

    always_comb begin
        w_sum = mm4_pkg::t_sum'(r_pair[0]) + mm4_pkg::t_sum'(r_pair[1]);
        if (w_sum > mm4_pkg::t_sum'(mm4_pkg::SAT_MAX)) begin
            o_value = mm4_pkg::SAT_MAX;
            o_sat   = 1'b1;
        end else if (w_sum < mm4_pkg::t_sum'(mm4_pkg::SAT_MIN)) begin
            o_value = mm4_pkg::SAT_MIN;
            o_sat   = 1'b1;
        end else begin
            o_value = w_sum[mm4_pkg::DATA_W-1:0];
            o_sat   = 1'b0;
        end
    end

endmodule

>>> hw/rtl/matrix_multiply_4x4_top.sv
`timescale 1ns / 1ps

// channel  | modport | beat
// i_cmd    | sink    | operation, column, elem_0..elem_3 (load or right column)
// o_res    | source  | result_column, out_0..out_3, saturated (multiply only)
//
// One beat per cycle unless o_res stalls. Each multiply beat passes registered steps:
// 16 multipliers, then pair adds, then the final add, clamp and row merge into o_res.
// Load beats write the stored matrix at once; the next beat already sees it.
// Reset clears the stored matrix to zero and empties the pipeline.
// Stages advance independently, so bubbles close up under o_res stalls.
module matrix_multiply_4x4_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mm4_in_if.sink    i_cmd,
    mm4_out_if.source o_res
);

    mm4_pkg::t_data      r_left [mm4_pkg::DIM*mm4_pkg::DIM];
    mm4_pkg::t_data      w_b    [mm4_pkg::DIM];
    mm4_pkg::t_data      w_val  [mm4_pkg::DIM];
    logic [mm4_pkg::DIM-1:0] w_sat;
    mm4_pkg::t_stage_ctl w_ctl;

    logic          r_v1, r_v2, r_v3;
    mm4_pkg::t_col r_col1, r_col2, r_col3;
    mm4_pkg::t_data r_out [mm4_pkg::DIM];
    logic          r_sat;
    logic          w_en3;
    logic          w_acc;

    assign w_en3     = !r_v3 || o_res.ready;
    assign w_ctl.en2 = !r_v2 || w_en3;
    assign w_ctl.en1 = !r_v1 || w_ctl.en2;
    assign i_cmd.ready = w_ctl.en1;
    assign w_acc     = i_cmd.valid && i_cmd.ready;

    assign w_b[0] = i_cmd.elem_0;
    assign w_b[1] = i_cmd.elem_1;
    assign w_b[2] = i_cmd.elem_2;
    assign w_b[3] = i_cmd.elem_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mm4_pkg::DIM*mm4_pkg::DIM; i++) begin
                r_left[i] <= '0;
            end
        end else if (w_acc && i_cmd.operation == mm4_pkg::OP_LOAD) begin
            for (int r = 0; r < mm4_pkg::DIM; r++) begin
                r_left[{i_cmd.column, 2'(r)}] <= w_b[r];
            end
        end
    end

    for (genvar r = 0; r < mm4_pkg::DIM; r++) begin : g_lane
        mm4_pkg::t_data w_a [mm4_pkg::DIM];
        for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_tap
            assign w_a[k] = r_left[k*mm4_pkg::DIM + r];
        end
        mm4_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_a     (w_a),
            .i_b     (w_b),
            .o_value (w_val[r]),
            .o_sat   (w_sat[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctl.en1) r_v1 <= w_acc && i_cmd.operation == mm4_pkg::OP_MUL;
            if (w_ctl.en2) r_v2 <= r_v1;
            if (w_en3)     r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en1) r_col1 <= i_cmd.column;
        if (w_ctl.en2) r_col2 <= r_col1;
        if (w_en3) begin
            r_col3 <= r_col2;
            r_out  <= w_val;
            r_sat  <= |w_sat;
        end
    end

    assign o_res.valid         = r_v3;
    assign o_res.result_column = r_col3;
    assign o_res.out_0         = r_out[0];
    assign o_res.out_1         = r_out[1];
    assign o_res.out_2         = r_out[2];
    assign o_res.out_3         = r_out[3];
    assign o_res.saturated     = r_sat;

endmodule
